@@ sv/tida_pkg.sv @@
// ----------------------------------------------------------------------------
// tida_pkg
// Types, codes and helper functions shared by the transaction ID allocator.
// ----------------------------------------------------------------------------
package tida_pkg;

   localparam logic [2:0] OP_NEW        = 3'd0;
   localparam logic [2:0] OP_DONE       = 3'd1;
   localparam logic [2:0] OP_VALIDATE   = 3'd2;
   localparam logic [2:0] OP_OVERRIDE   = 3'd3;
   localparam logic [2:0] OP_TICK       = 3'd4;
   localparam logic [2:0] OP_NODE_RESET = 3'd5;

   localparam logic [15:0] HOLD_RESET   = 16'd24000;
   localparam logic [2:0]  DOM_LEN_MAX  = 3'd6;

   typedef struct packed {
      logic [2:0]  opcode;
      logic        priority_req;
      logic [1:0]  addr_mode;
      logic [47:0] dest_addr;
      logic [2:0]  dom_len;
      logic [47:0] dom_id;
      logic [3:0]  tid_value;
      logic        clear_tables;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] tid_out;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LATCH,
      DP_READ,
      DP_TREAD,
      DP_FOUND,
      DP_MOVE,
      DP_NEW,
      DP_APPEND,
      DP_TICK,
      DP_FAIL,
      DP_SIMPLE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      cls;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       busy;
      logic       empty;
      logic       full;
      logic       scan_last;
      logic       match;
      logic       expired;
      logic       out_free;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FOUND,
      ST_EXP_RD,
      ST_EXP_CHK,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_NEW_WR,
      ST_APPEND,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_FAIL,
      ST_SIMPLE
   } state_type;

   function automatic logic [3:0] bump_tid(input logic [3:0] t);
      return (t == 4'd15) ? 4'd1 : t + 4'd1;
   endfunction

   function automatic logic [47:0] dom_mask(input logic [2:0] len);
      logic [47:0] m;
      case (len)
         3'd0:    m = 48'h0;
         3'd1:    m = 48'hFF;
         3'd2:    m = 48'hFFFF;
         3'd3:    m = 48'hFF_FFFF;
         3'd4:    m = 48'hFFFF_FFFF;
         3'd5:    m = 48'hFF_FFFF_FFFF;
         default: m = 48'hFFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

@@ sv/tida_datapath.sv @@
// ----------------------------------------------------------------------------
// tida_datapath
// Class registers, destination tables, hold time and result register.
// ----------------------------------------------------------------------------
module tida_datapath import tida_pkg::*; #(
   parameter int TABLE_ENTRIES = 16,
   parameter int ADDR_BITS     = 48,
   parameter int IDX_W         = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  cmd_type          cmd,
   input  logic [IDX_W-1:0] cmd_idx,
   output status_type       status
);

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int DEPTH = 2 ** (IDX_W + 1);

   req_type          req_ff;
   logic [15:0]      hold_ff;
   logic [3:0]       next_tid_ff [2];
   logic [3:0]       active_ff   [2];
   logic             busy_ff     [2];
   logic [CNT_W-1:0] count_ff    [2];
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic [1:0]           mem_mode  [DEPTH];
   logic [ADDR_BITS-1:0] mem_addr  [DEPTH];
   logic [2:0]           mem_len   [DEPTH];
   logic [47:0]          mem_dom   [DEPTH];
   logic [3:0]           mem_tid   [DEPTH];
   logic [15:0]          mem_timer [DEPTH];

   logic [1:0]           rd_mode_ff;
   logic [ADDR_BITS-1:0] rd_addr_ff;
   logic [2:0]           rd_len_ff;
   logic [47:0]          rd_dom_ff;
   logic [3:0]           rd_tid_ff;
   logic [15:0]          rd_timer_ff;

   logic                 c;
   logic [2:0]           dlen;
   logic [47:0]          did;
   logic [ADDR_BITS-1:0] key_addr;
   logic [3:0]           next_c;
   logic [3:0]           found_tid;
   logic [CNT_W-1:0]     count_c;
   logic                 out_free;
   logic                 finishing;

   logic                 rd_en;
   logic [IDX_W:0]       rd_a;
   logic                 wr_all;
   logic                 wr_timer;
   logic [IDX_W:0]       wr_a;
   logic [1:0]           wr_mode;
   logic [ADDR_BITS-1:0] wr_addr;
   logic [2:0]           wr_len;
   logic [47:0]          wr_dom;
   logic [3:0]           wr_tid;
   logic [15:0]          wr_tmr;

   assign c         = req_ff.priority_req;
   assign dlen      = (req_ff.dom_len > DOM_LEN_MAX) ? DOM_LEN_MAX : req_ff.dom_len;
   assign did       = req_ff.dom_id & dom_mask(dlen);
   assign key_addr  = req_ff.dest_addr[ADDR_BITS-1:0];
   assign next_c    = next_tid_ff[c];
   assign count_c   = count_ff[c];
   assign found_tid = (rd_tid_ff == next_c) ? bump_tid(next_c) : next_c;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finishing = (cmd.op == DP_FOUND) || (cmd.op == DP_NEW) || (cmd.op == DP_APPEND) ||
                      (cmd.op == DP_FAIL) || (cmd.op == DP_SIMPLE);

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status.op        = req_ff.opcode;
      status.busy      = busy_ff[c];
      status.empty     = (count_c == '0);
      status.full      = (count_c == CNT_W'(TABLE_ENTRIES));
      status.scan_last = (CNT_W'(cmd_idx) + CNT_W'(1)) == count_c;
      status.match     = (rd_len_ff == dlen) && (rd_dom_ff == did) &&
                         (rd_mode_ff == req_ff.addr_mode) && (rd_addr_ff == key_addr);
      status.expired   = (rd_timer_ff == 16'd0);
      status.out_free  = out_free;
   end

   always_comb begin
      rd_en    = (cmd.op == DP_READ) || (cmd.op == DP_TREAD);
      rd_a     = (cmd.op == DP_TREAD) ? {cmd.cls, cmd_idx} : {c, cmd_idx};
      wr_all   = 1'b0;
      wr_timer = 1'b0;
      wr_a     = {c, cmd_idx};
      wr_mode  = req_ff.addr_mode;
      wr_addr  = key_addr;
      wr_len   = dlen;
      wr_dom   = did;
      wr_tid   = next_c;
      wr_tmr   = hold_ff;
      case (cmd.op)
         DP_FOUND: begin
            wr_all   = 1'b1;
            wr_timer = 1'b1;
            wr_mode  = rd_mode_ff;
            wr_addr  = rd_addr_ff;
            wr_len   = rd_len_ff;
            wr_dom   = rd_dom_ff;
            wr_tid   = found_tid;
         end
         DP_MOVE: begin
            wr_all   = 1'b1;
            wr_timer = 1'b1;
            wr_mode  = rd_mode_ff;
            wr_addr  = rd_addr_ff;
            wr_len   = rd_len_ff;
            wr_dom   = rd_dom_ff;
            wr_tid   = rd_tid_ff;
            wr_tmr   = rd_timer_ff;
         end
         DP_NEW: begin
            wr_all   = 1'b1;
            wr_timer = 1'b1;
         end
         DP_APPEND: begin
            wr_all   = 1'b1;
            wr_timer = 1'b1;
            wr_a     = {c, count_c[IDX_W-1:0]};
         end
         DP_TICK: begin
            wr_timer = 1'b1;
            wr_a     = {cmd.cls, cmd_idx};
            wr_tmr   = (rd_timer_ff == 16'd0) ? 16'd0 : rd_timer_ff - 16'd1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in.ok      = 1'b1;
      rsp_in.tid_out = 4'd0;
      case (cmd.op)
         DP_FOUND:  rsp_in.tid_out = found_tid;
         DP_NEW:    rsp_in.tid_out = next_c;
         DP_APPEND: rsp_in.tid_out = next_c;
         DP_FAIL:   rsp_in.ok      = 1'b0;
         DP_SIMPLE: begin
            if (req_ff.opcode == OP_VALIDATE) begin
               rsp_in.ok = busy_ff[c] && (active_ff[c] == req_ff.tid_value);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_all) begin
         mem_mode[wr_a] <= wr_mode;
         mem_addr[wr_a] <= wr_addr;
         mem_len[wr_a]  <= wr_len;
         mem_dom[wr_a]  <= wr_dom;
         mem_tid[wr_a]  <= wr_tid;
      end
      if (wr_timer) begin
         mem_timer[wr_a] <= wr_tmr;
      end
      if (rd_en) begin
         rd_mode_ff  <= mem_mode[rd_a];
         rd_addr_ff  <= mem_addr[rd_a];
         rd_len_ff   <= mem_len[rd_a];
         rd_dom_ff   <= mem_dom[rd_a];
         rd_tid_ff   <= mem_tid[rd_a];
         rd_timer_ff <= mem_timer[rd_a];
      end
      if (cmd.op == DP_LATCH) begin
         req_ff <= req_data;
      end
      if (finishing) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= HOLD_RESET;
         next_tid_ff  <= '{default: 4'd0};
         active_ff    <= '{default: 4'd0};
         busy_ff      <= '{default: 1'b0};
         count_ff     <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            hold_ff <= csr_data;
         end
         if (finishing) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            DP_FOUND: begin
               next_tid_ff[c] <= found_tid;
               active_ff[c]   <= found_tid;
               busy_ff[c]     <= 1'b1;
            end
            DP_NEW: begin
               active_ff[c] <= next_c;
               busy_ff[c]   <= 1'b1;
            end
            DP_APPEND: begin
               active_ff[c] <= next_c;
               busy_ff[c]   <= 1'b1;
               count_ff[c]  <= count_c + CNT_W'(1);
            end
            DP_SIMPLE: begin
               case (req_ff.opcode)
                  OP_DONE: begin
                     busy_ff[c]     <= 1'b0;
                     next_tid_ff[c] <= bump_tid(next_c);
                  end
                  OP_OVERRIDE: begin
                     next_tid_ff[c] <= req_ff.tid_value;
                     active_ff[c]   <= req_ff.tid_value;
                  end
                  OP_NODE_RESET: begin
                     next_tid_ff <= '{default: 4'd0};
                     busy_ff     <= '{default: 1'b0};
                     if (req_ff.clear_tables) begin
                        count_ff <= '{default: '0};
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[0] <= CNT_W'(TABLE_ENTRIES) && count_ff[1] <= CNT_W'(TABLE_ENTRIES))
      else $error("table count above capacity");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      finishing |-> out_free)
      else $error("result written while output occupied");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.ok || rsp_ff.tid_out == 4'd0))
      else $error("failed result carries an ID");

endmodule

@@ sv/tida_controller.sv @@
// ----------------------------------------------------------------------------
// tida_controller
// Sequencer for table scans, entry replacement, the timer sweep and simple requests.
// ----------------------------------------------------------------------------
module tida_controller import tida_pkg::*; #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  status_type       status,
   output cmd_type          cmd,
   output logic [IDX_W-1:0] cmd_idx
);

   localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             cls_ff, cls_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cls_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cls_ff   <= cls_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cls_in    = cls_ff;
      cmd.op    = DP_NONE;
      cmd.cls   = cls_ff;
      cmd_idx   = idx_ff;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LATCH;
               state_in = ST_START;
            end
         end
         ST_START: begin
            case (status.op)
               OP_NEW: begin
                  idx_in = '0;
                  if (status.busy) begin
                     state_in = ST_FAIL;
                  end else if (status.empty) begin
                     state_in = ST_APPEND;
                  end else begin
                     state_in = ST_SCAN_RD;
                  end
               end
               OP_TICK: begin
                  idx_in   = '0;
                  cls_in   = 1'b0;
                  state_in = ST_TICK_RD;
               end
               default: state_in = ST_SIMPLE;
            endcase
         end
         ST_SCAN_RD: begin
            cmd.op   = DP_READ;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (status.match) begin
               state_in = ST_FOUND;
            end else if (status.scan_last) begin
               idx_in   = '0;
               state_in = status.full ? ST_EXP_RD : ST_APPEND;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_FOUND: begin
            if (status.out_free) begin
               cmd.op   = DP_FOUND;
               state_in = ST_IDLE;
            end
         end
         ST_EXP_RD: begin
            cmd.op   = DP_READ;
            state_in = ST_EXP_CHK;
         end
         ST_EXP_CHK: begin
            if (status.expired) begin
               state_in = ST_MOVE_RD;
            end else if (idx_ff == LAST) begin
               state_in = ST_FAIL;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_EXP_RD;
            end
         end
         ST_MOVE_RD: begin
            cmd.op   = DP_READ;
            cmd_idx  = LAST;
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            cmd.op   = DP_MOVE;
            state_in = ST_NEW_WR;
         end
         ST_NEW_WR: begin
            cmd_idx = LAST;
            if (status.out_free) begin
               cmd.op   = DP_NEW;
               state_in = ST_IDLE;
            end
         end
         ST_APPEND: begin
            if (status.out_free) begin
               cmd.op   = DP_APPEND;
               state_in = ST_IDLE;
            end
         end
         ST_TICK_RD: begin
            cmd.op   = DP_TREAD;
            state_in = ST_TICK_WR;
         end
         ST_TICK_WR: begin
            cmd.op = DP_TICK;
            if (idx_ff == LAST) begin
               idx_in = '0;
               if (cls_ff) begin
                  state_in = ST_SIMPLE;
               end else begin
                  cls_in   = 1'b1;
                  state_in = ST_TICK_RD;
               end
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_TICK_RD;
            end
         end
         ST_FAIL: begin
            if (status.out_free) begin
               cmd.op   = DP_FAIL;
               state_in = ST_IDLE;
            end
         end
         ST_SIMPLE: begin
            if (status.out_free) begin
               cmd.op   = DP_SIMPLE;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ sv/transaction_id_allocator_core.sv @@
// ----------------------------------------------------------------------------
// transaction_id_allocator_core
// Two-class transaction ID allocator with per-class destination tables.
// ----------------------------------------------------------------------------
// Done, validate, override and node reset: latch, decode, then the result.
// New: a read and a check per table entry scanned, plus a read and a check per
// entry searched for expiry when the table is full.
// Tick: a read and a write per entry of both tables.
// Table entries are read one at a time; one request at a time.
// Reset clears IDs, busy flags and counts; table contents stay undefined.
module transaction_id_allocator_core import tida_pkg::*; #(
   parameter int TABLE_ENTRIES = 16,
   parameter int ADDR_BITS     = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   cmd_type          cmd;
   logic [IDX_W-1:0] cmd_idx;
   status_type       status;

   tida_controller #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IDX_W        (IDX_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd),
      .cmd_idx  (cmd_idx)
   );

   tida_datapath #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .ADDR_BITS    (ADDR_BITS),
      .IDX_W        (IDX_W)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .cmd_idx  (cmd_idx),
      .status   (status)
   );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for transaction_id_allocator_core: directed and random
// requests in bursts against a behavioral allocator, responses checked in order.
// ----------------------------------------------------------------------------
module tb;
   import tida_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int         ENTRIES     = 16;
   localparam int         POOL        = 22;
   localparam int         IDLE_LIMIT  = 3000;
   localparam int         DRAIN       = 120;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   transaction_id_allocator_core #(.TABLE_ENTRIES(ENTRIES), .ADDR_BITS(48)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // allocator state
   logic [15:0] hold_ticks;
   logic [3:0]  next_id   [2];
   logic [3:0]  active_id [2];
   logic        busy_flag [2];
   int          tbl_count [2];
   logic [1:0]  tbl_mode  [2][ENTRIES];
   logic [47:0] tbl_addr  [2][ENTRIES];
   logic [2:0]  tbl_dlen  [2][ENTRIES];
   logic [47:0] tbl_did   [2][ENTRIES];
   logic [3:0]  tbl_tid   [2][ENTRIES];
   logic [15:0] tbl_timer [2][ENTRIES];

   req_type     pending_reqs[$];
   rsp_type     expected_rsps[$];
   int          mismatches;
   int          idle_cycles;
   int          burst_left;
   int          gap_left;
   int          stall_mode;
   int          stall_age;
   int          hold_left;
   int          rsp_seen;

   // destination pool for well-formed sequences
   logic [1:0]  pool_mode [POOL];
   logic [47:0] pool_addr [POOL];
   logic [2:0]  pool_dlen [POOL];
   logic [47:0] pool_did  [POOL];

   function automatic logic [3:0] next_in_seq(logic [3:0] t);
      return (t >= 4'd15) ? 4'd1 : t + 4'd1;
   endfunction

   function automatic logic [47:0] byte_mask(logic [2:0] len);
      logic [63:0] m;
      m = (64'd1 << (8 * len)) - 64'd1;
      return m[47:0];
   endfunction

   function automatic void model_state_reset();
      hold_ticks = HOLD_RESET;
      for (int c = 0; c < 2; c++) begin
         next_id[c] = '0; active_id[c] = '0; busy_flag[c] = 1'b0; tbl_count[c] = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            tbl_mode[c][i] = '0; tbl_addr[c][i] = '0; tbl_dlen[c][i] = '0;
            tbl_did[c][i] = '0; tbl_tid[c][i] = '0; tbl_timer[c][i] = '0;
         end
      end
   endfunction

   function automatic rsp_type allocate_id(req_type r);
      rsp_type     o;
      int          c, n, k, i;
      logic [2:0]  dlen;
      logic [47:0] did;
      c = r.priority_req;
      o.ok = 1'b1;
      o.tid_out = '0;
      dlen = (r.dom_len > DOM_LEN_MAX) ? DOM_LEN_MAX : r.dom_len;
      did = r.dom_id & byte_mask(dlen);
      case (r.opcode)
         OP_NEW: begin
            if (busy_flag[c]) begin
               o.ok = 1'b0;
               return o;
            end
            n = tbl_count[c];
            k = -1;
            for (i = 0; i < n; i++)
               if (k < 0 && tbl_dlen[c][i] == dlen && (tbl_did[c][i] & byte_mask(dlen)) == did
                   && tbl_mode[c][i] == r.addr_mode && tbl_addr[c][i] == r.dest_addr)
                  k = i;
            if (k >= 0) begin
               if (tbl_tid[c][k] == next_id[c]) next_id[c] = next_in_seq(next_id[c]);
               tbl_tid[c][k] = next_id[c];
               tbl_timer[c][k] = hold_ticks;
            end else begin
               if (n >= ENTRIES) begin
                  for (i = 0; i < n; i++)
                     if (tbl_timer[c][i] == 0) break;
                  if (i >= n) begin
                     o.ok = 1'b0;
                     return o;
                  end
                  n--;
                  tbl_mode[c][i] = tbl_mode[c][n]; tbl_addr[c][i] = tbl_addr[c][n];
                  tbl_dlen[c][i] = tbl_dlen[c][n]; tbl_did[c][i] = tbl_did[c][n];
                  tbl_tid[c][i] = tbl_tid[c][n]; tbl_timer[c][i] = tbl_timer[c][n];
               end
               tbl_mode[c][n] = r.addr_mode; tbl_addr[c][n] = r.dest_addr;
               tbl_dlen[c][n] = dlen; tbl_did[c][n] = did;
               tbl_tid[c][n] = next_id[c]; tbl_timer[c][n] = hold_ticks;
               tbl_count[c] = n + 1;
            end
            active_id[c] = next_id[c];
            busy_flag[c] = 1'b1;
            o.tid_out = next_id[c];
         end
         OP_DONE: begin
            busy_flag[c] = 1'b0;
            next_id[c] = next_in_seq(next_id[c]);
         end
         OP_VALIDATE: o.ok = busy_flag[c] && active_id[c] == r.tid_value;
         OP_OVERRIDE: begin
            next_id[c] = r.tid_value;
            active_id[c] = r.tid_value;
         end
         OP_TICK: begin
            for (int j = 0; j < 2; j++)
               for (i = 0; i < ENTRIES; i++)
                  if (tbl_timer[j][i] != 0) tbl_timer[j][i] = tbl_timer[j][i] - 16'd1;
         end
         OP_NODE_RESET: begin
            next_id[0] = '0; next_id[1] = '0;
            busy_flag[0] = 1'b0; busy_flag[1] = 1'b0;
            if (r.clear_tables) begin
               tbl_count[0] = 0; tbl_count[1] = 0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic req_type noise_req(logic [2:0] op);
      req_type r;
      r.opcode = op;
      r.priority_req = 1'($urandom_range(0, 1));
      r.addr_mode = 2'($urandom_range(0, 3));
      r.dest_addr = 48'({$urandom, $urandom});
      r.dom_len = 3'($urandom_range(0, 7));
      r.dom_id = 48'({$urandom, $urandom});
      r.tid_value = 4'($urandom_range(0, 15));
      r.clear_tables = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic req_type pool_req(logic [2:0] op, logic cls);
      req_type r;
      int      p;
      p = $urandom_range(0, POOL - 1);
      r = noise_req(op);
      r.priority_req = cls;
      r.addr_mode = pool_mode[p];
      r.dest_addr = pool_addr[p];
      r.dom_len = pool_dlen[p];
      // bytes beyond dom_len are don't-care and vary
      r.dom_id = (pool_did[p] & byte_mask(pool_dlen[p]))
                 | (48'({$urandom, $urandom}) & ~byte_mask(pool_dlen[p]));
      return r;
   endfunction

   task automatic fill_pool();
      for (int p = 0; p < POOL; p++) begin
         pool_mode[p] = 2'($urandom_range(0, 3));
         pool_addr[p] = 48'({$urandom, $urandom});
         pool_dlen[p] = 3'($urandom_range(0, 7));
         pool_did[p] = 48'({$urandom, $urandom});
      end
   endtask

   task automatic queue_random(int count);
      int      sel, added;
      logic    cls;
      req_type r;
      added = 0;
      while (added < count) begin
         sel = $urandom_range(0, 99);
         cls = 1'($urandom_range(0, 1));
         if (sel < 55) begin
            pending_reqs.push_back(pool_req(OP_NEW, cls));
            if ($urandom_range(0, 2) == 0) begin
               r = noise_req(OP_VALIDATE);
               r.priority_req = cls;
               pending_reqs.push_back(r);
               added++;
            end
            if ($urandom_range(0, 9) != 0) begin
               r = noise_req(OP_DONE);
               r.priority_req = cls;
               pending_reqs.push_back(r);
               added++;
            end
            added++;
         end else if (sel < 75) begin
            pending_reqs.push_back(noise_req(OP_TICK));
            added++;
         end else if (sel < 83) begin
            pending_reqs.push_back(noise_req(OP_VALIDATE));
            added++;
         end else if (sel < 88) begin
            pending_reqs.push_back(noise_req(OP_OVERRIDE));
            added++;
         end else if (sel < 93) begin
            pending_reqs.push_back(noise_req(OP_NEW));
            added++;
         end else if (sel < 96) begin
            pending_reqs.push_back(noise_req(OP_DONE));
            added++;
         end else if (sel < 98) begin
            r = noise_req(OP_NODE_RESET);
            r.clear_tables = ($urandom_range(0, 3) == 0);
            pending_reqs.push_back(r);
            added++;
         end else begin
            pending_reqs.push_back(noise_req($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI));
            added++;
         end
      end
   endtask

   task automatic queue_directed();
      req_type r;
      r = noise_req(OP_VALIDATE); r.priority_req = 0; r.tid_value = 0;
      pending_reqs.push_back(r);
      r = noise_req(OP_DONE); r.priority_req = 1; pending_reqs.push_back(r);
      r = noise_req(OP_NEW); r.priority_req = 0; r.addr_mode = 3;
      r.dest_addr = '1; r.dom_len = 7; r.dom_id = '1; pending_reqs.push_back(r);
      r.opcode = OP_NEW; pending_reqs.push_back(r);
      r.opcode = OP_VALIDATE; r.tid_value = 0; pending_reqs.push_back(r);
      r.opcode = OP_DONE; pending_reqs.push_back(r);
      r.opcode = OP_OVERRIDE; r.tid_value = 15; pending_reqs.push_back(r);
      r.opcode = OP_NEW; r.dom_len = 6; pending_reqs.push_back(r);
      r.opcode = OP_VALIDATE; r.tid_value = 15; pending_reqs.push_back(r);
      r.opcode = OP_DONE; pending_reqs.push_back(r);
      r.opcode = OP_NEW; r.addr_mode = 0; r.dest_addr = '0; r.dom_len = 0; r.dom_id = '0;
      pending_reqs.push_back(r);
      r.opcode = OP_DONE; pending_reqs.push_back(r);
      r.opcode = OP_NEW; pending_reqs.push_back(r);
      r.opcode = OP_DONE; pending_reqs.push_back(r);
      r = noise_req(OP_NEW); r.priority_req = 1; pending_reqs.push_back(r);
      r.opcode = OP_OVERRIDE; r.tid_value = 0; pending_reqs.push_back(r);
      pending_reqs.push_back(noise_req(OP_TICK));
      pending_reqs.push_back(noise_req(OP_SPARE_LO));
      pending_reqs.push_back(noise_req(OP_SPARE_HI));
      r = noise_req(OP_NODE_RESET); r.clear_tables = 0; pending_reqs.push_back(r);
      r = noise_req(OP_VALIDATE); r.priority_req = 1; pending_reqs.push_back(r);
      r = noise_req(OP_NODE_RESET); r.clear_tables = 1; pending_reqs.push_back(r);
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_hold(logic [15:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      hold_ticks = v;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(allocate_id(req_data));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 30);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall pattern, with a long hold-off every 150 transfers
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_mode <= 0;
         stall_age <= 0;
         hold_left <= 0;
         rsp_seen <= 0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_seen <= rsp_seen + 1;
         if (rsp_valid && rsp_ready && rsp_seen % 150 == 75) begin
            hold_left <= 400;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (stall_age >= 64) begin
               stall_age <= 0;
               stall_mode <= $urandom_range(0, 2);
            end else begin
               stall_age <= stall_age + 1;
            end
            case (stall_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("unexpected transfer: ok=%0d tid=%0d",
                                          rsp_data.ok, rsp_data.tid_out);
         end else begin
            want = expected_rsps.pop_front();
            if (want.ok !== rsp_data.ok || want.tid_out !== rsp_data.tid_out) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("mismatch: expected ok=%0d tid=%0d, got ok=%0d tid=%0d",
                           want.ok, want.tid_out, rsp_data.ok, rsp_data.tid_out);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready) || (!req_valid && expected_rsps.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("transaction_id_allocator_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [15:0] holds [6];
      holds = '{16'd1, 16'd0, 16'd65535, 16'd3, 16'd2, 16'd1};
      mismatches = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      model_state_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      queue_directed();
      fill_pool();
      queue_random(90);
      wait_idle();
      for (int ph = 0; ph < 6; ph++) begin
         write_hold(holds[ph]);
         fill_pool();
         queue_random(85);
         wait_idle();
      end
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("transaction_id_allocator_core test passed");
      else
         $display("transaction_id_allocator_core test failed");
      $finish;
   end

endmodule
